// ===== hdl/msp_pkg.sv =====
// Shared constants, divider handshake types and lookup functions of the signature profiler.
package msp_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int PAYLOAD_BYTES_DEF = 8;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] FREQ_SCALE = 32'd1000000;

	localparam logic [1:0] STS_HIT  = 2'd0;
	localparam logic [1:0] STS_NEW  = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;
	localparam logic [1:0] STS_SRST = 2'd3;

	localparam logic [2:0] CAT_NONE      = 3'd0;
	localparam logic [2:0] CAT_RESET     = 3'd1;
	localparam logic [2:0] CAT_TELEMETRY = 3'd2;
	localparam logic [2:0] CAT_PERIODIC  = 3'd3;
	localparam logic [2:0] CAT_RESPONSE  = 3'd4;
	localparam logic [2:0] CAT_STATE     = 3'd5;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	function automatic logic [14:0] log2_q12(input logic [4:0] n);
		logic [14:0] r;
		case (n)
			5'd2:  r = 15'd4096;
			5'd3:  r = 15'd6492;
			5'd4:  r = 15'd8192;
			5'd5:  r = 15'd9510;
			5'd6:  r = 15'd10592;
			5'd7:  r = 15'd11497;
			5'd8:  r = 15'd12288;
			5'd9:  r = 15'd12992;
			5'd10: r = 15'd13622;
			5'd11: r = 15'd14200;
			5'd12: r = 15'd14723;
			5'd13: r = 15'd15210;
			5'd14: r = 15'd15655;
			5'd15: r = 15'd16077;
			5'd16: r = 15'd16473;
			default: r = 15'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] entropy_score_of(input logic [31:0] avg);
		logic [32:0] r;
		logic [20:0] bits;
		logic [7:0] s;
		r = {1'b0, avg} + 33'd2048;
		bits = r[32:12];
		case (bits)
			21'd0: s = 8'd0;
			21'd1: s = 8'd63;
			21'd2: s = 8'd127;
			21'd3: s = 8'd191;
			default: s = 8'd255;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/message_signature_profiler.sv =====
// Top level of the message signature profiler: hash, table search, update and allocation.
//
//  channel | signals                      | direction | transfer
//  in      | in_valid, in_stall, fields   | to block  | in_valid && !in_stall
//  out     | out_valid, out_stall, fields | from block| out_valid && !out_stall
//
// One item at a time. The hash covers SOP, type and up to six payload bytes, the search
// compares the signature RAM entry by entry over the allocated entries, a hit reads the
// record and takes up to two divider passes, and an allocation runs a 16-bin histogram,
// at most one divider pass and one write. Each result is handed to the output register.
// Session reset clears all per-entry valid bits together; no clearing pass is needed.
// A result waits in the output register; the next item is taken meanwhile.
module message_signature_profiler import msp_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  sop,
	input  logic [7:0]  msg_type,
	input  logic [63:0] payload_bytes,
	input  logic [3:0]  payload_length,
	input  logic [7:0]  vbus_low_byte,
	input  logic [7:0]  current_low_byte,
	input  logic [7:0]  temperature_low_byte,
	input  logic [2:0]  event_flags,
	input  logic [7:0]  previous_type,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  entry_index,
	output logic [2:0]  category,
	output logic [6:0]  confidence,
	output logic [7:0]  entropy_score,
	output logic [19:0] frequency_milli,
	output logic [31:0] hit_count,
	output logic [3:0]  stable_average,
	output logic [3:0]  changing_average
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] TE_C = CW'(TABLE_ENTRIES);
	localparam logic [3:0] PB4 = 4'(PAYLOAD_BYTES);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_HASH  = 4'd1;
	localparam logic [3:0] ST_SRD   = 4'd2;
	localparam logic [3:0] ST_SCMP  = 4'd3;
	localparam logic [3:0] ST_RRD   = 4'd4;
	localparam logic [3:0] ST_RLD   = 4'd5;
	localparam logic [3:0] ST_IVL   = 4'd6;
	localparam logic [3:0] ST_DIV1  = 4'd7;
	localparam logic [3:0] ST_DIV2  = 4'd8;
	localparam logic [3:0] ST_UPD   = 4'd9;
	localparam logic [3:0] ST_ENT   = 4'd10;
	localparam logic [3:0] ST_EDIV  = 4'd11;
	localparam logic [3:0] ST_ALLOC = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	typedef struct packed {
		logic [63:0] prev;
		logic [31:0] sess;
		logic [31:0] total;
		logic [31:0] last;
		logic [31:0] isum;
		logic [31:0] icnt;
		logic [19:0] freq;
		logic [3:0]  stab;
		logic [3:0]  chg;
		logic [31:0] flips;
		logic [7:0]  vm;
		logic [7:0]  cm;
		logic [7:0]  tm;
		logic [15:0] rl;
		logic [15:0] al;
		logic [7:0]  lt;
		logic [2:0]  cat;
		logic [6:0]  conf;
		logic [7:0]  ent;
	} rec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  idx;
		logic [2:0]  cat;
		logic [6:0]  conf;
		logic [7:0]  ent;
		logic [19:0] freq;
		logic [31:0] hits;
		logic [3:0]  stab;
		logic [3:0]  chg;
	} res_t;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [TABLE_ENTRIES-1:0] sess_ok_q;
	logic          out_valid_q;

	logic [7:0]  sop_q, type_q, vb_q, cu_q, te_q, prv_q;
	logic [63:0] pay_q;
	logic [3:0]  cap_q, step_q, bin_q;
	logic [2:0]  flg_q;
	logic [31:0] now_q, h_q;
	logic [IW-1:0] e_q;
	logic [19:0] acc_q;
	logic [7:0]  ent_q;
	rec_t        rec_q, nr, ar, rec_rd;
	res_t        res_q, out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [31:0] sig_rd;

	logic        accept;
	logic [3:0]  cap_in, hn;
	logic [7:0]  hb;
	logic [2:0]  bsel;
	logic [31:0] h_nx;
	logic [CW-1:0] e_nx;
	logic        hit, out_free;
	logic [31:0] sess_eff, iv, isum_nx, icnt_nx;
	logic        take;
	logic [15:0] nmask;
	logic [4:0]  hist, tot;
	logic [14:0] lt_tot, lt_h, dd;
	logic [19:0] acc_nx;
	logic [63:0] keep;
	logic        rec_we, sig_we, rec_re, sig_re;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cap_in   = (payload_length > PB4) ? PB4 : payload_length;

	// hash step
	assign hn   = 4'd2 + ((cap_q > 4'd6) ? 4'd6 : cap_q);
	assign bsel = 3'(step_q - 4'd2);
	always_comb begin
		case (step_q)
			4'd0: hb = sop_q;
			4'd1: hb = type_q;
			default: hb = pay_q[{bsel, 3'b000} +: 8];
		endcase
	end
	assign h_nx = (h_q ^ {24'd0, hb}) * FNV_PRIME;

	assign e_nx = CW'(e_q) + CW'(1);
	assign hit  = (sig_rd == h_q);

	// interval
	assign sess_eff = sess_ok_q[e_q] ? rec_q.sess : 32'd0;
	assign iv       = now_q - rec_q.last;
	assign take     = (rec_q.last != 32'd0) && (sess_eff != 32'd0) && (iv != 32'd0);
	assign isum_nx  = rec_q.isum + iv;
	assign icnt_nx  = rec_q.icnt + 32'd1;

	// histogram bin
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			nmask[i] = (4'(i / 2) < cap_q) && (pay_q[i*4 +: 4] == bin_q);
		end
	end
	assign hist   = 5'($countones(nmask));
	assign tot    = {cap_q, 1'b0};
	assign lt_tot = log2_q12(tot);
	assign lt_h   = log2_q12(hist);
	assign dd     = (lt_tot > lt_h) ? (lt_tot - lt_h) : 15'd0;
	assign acc_nx = acc_q + (20'(hist) * 20'(dd));

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {12'd0, acc_nx};
		div_req.divisor  = {27'd0, tot};
		case (state_q)
			ST_IVL: begin
				div_req.start    = take && (icnt_nx != 32'd0);
				div_req.dividend = isum_nx;
				div_req.divisor  = icnt_nx;
			end
			ST_DIV1: begin
				div_req.start    = div_rsp.done && (div_rsp.quotient != 32'd0);
				div_req.dividend = FREQ_SCALE;
				div_req.divisor  = div_rsp.quotient;
			end
			ST_ENT: begin
				div_req.start = (bin_q == 4'd15) && (cap_q != 4'd0);
			end
			default: ;
		endcase
	end

	// hit update
	always_comb begin
		logic [3:0] nst, nch, nv, nc, nt;
		logic [6:0] nfl;
		logic [8:0] sv, sc, st;
		logic pres, anym, c1, c2, c3, c4, c5;
		logic [7:0] a, b;
		nst = '0; nch = '0; nv = '0; nc = '0; nt = '0; nfl = '0;
		nr = rec_q;
		for (int k = 0; k < 8; k++) begin
			pres = (4'(k) < cap_q);
			a = rec_q.prev[k*8 +: 8];
			b = pay_q[k*8 +: 8];
			if (pres) begin
				if (a == b) nst = nst + 4'd1; else nch = nch + 4'd1;
				nfl = nfl + 7'($countones(a ^ b));
				nr.prev[k*8 +: 8] = b;
				if (b == vb_q) nv = nv + 4'd1;
				if (b == cu_q) nc = nc + 4'd1;
				if (b == te_q) nt = nt + 4'd1;
			end
		end
		nr.sess  = sess_eff + 32'd1;
		nr.total = rec_q.total + 32'd1;
		nr.last  = now_q;
		nr.flips = rec_q.flips + 32'(nfl);
		nr.stab  = 4'((5'(rec_q.stab) + 5'(nst)) >> 1);
		nr.chg   = 4'((5'(rec_q.chg) + 5'(nch)) >> 1);
		sv = {1'b0, rec_q.vm} + 9'(nv);
		sc = {1'b0, rec_q.cm} + 9'(nc);
		st = {1'b0, rec_q.tm} + 9'(nt);
		nr.vm = sv[8] ? 8'hFF : sv[7:0];
		nr.cm = sc[8] ? 8'hFF : sc[7:0];
		nr.tm = st[8] ? 8'hFF : st[7:0];
		nr.rl = rec_q.rl + 16'(flg_q[0]);
		nr.al = rec_q.al + 16'(flg_q[2]);
		if (prv_q != 8'hFF) nr.lt = prv_q;
		anym = (nr.vm != 8'd0) || (nr.cm != 8'd0) || (nr.tm != 8'd0);
		c1 = (nr.rl != 16'd0) && ({1'b0, nr.sess} <= (33'(nr.rl) + 33'd2));
		c2 = (nr.icnt >= 32'd2) && (nr.sess >= 32'd3) && (nr.freq >= 20'd1000) && anym;
		c3 = (nr.icnt >= 32'd3) && (nr.freq >= 20'd1000);
		c4 = (nr.lt != 8'hFF) && (nr.sess >= 32'd3);
		c5 = (nr.al != 16'd0) && ({1'b0, nr.sess} <= (33'(nr.al) + 33'd2));
		if (c1) nr.cat = CAT_RESET;
		else if (c2) nr.cat = CAT_TELEMETRY;
		else if (c3) nr.cat = CAT_PERIODIC;
		else if (c4) nr.cat = CAT_RESPONSE;
		else if (c5) nr.cat = CAT_STATE;
		else nr.cat = CAT_NONE;
		nr.conf = 7'd40;
		if (nr.total >= 32'd2) nr.conf = nr.conf + 7'd20;
		if (nr.icnt >= 32'd3) nr.conf = nr.conf + 7'd15;
		if (nr.sess >= 32'd10) nr.conf = nr.conf + 7'd15;
		if ((nr.vm != 8'd0) || (nr.cm != 8'd0) || (nr.rl != 16'd0)) nr.conf = nr.conf + 7'd10;
	end

	// fresh entry
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			keep[k*8 +: 8] = (4'(k) < cap_q) ? 8'hFF : 8'h00;
		end
		ar       = '0;
		ar.prev  = pay_q & keep;
		ar.sess  = 32'd1;
		ar.total = 32'd1;
		ar.last  = now_q;
		ar.lt    = (prv_q != 8'hFF) ? prv_q : 8'd0;
		ar.conf  = 7'd20;
		ar.ent   = ent_q;
	end

	assign sig_re = (state_q == ST_SRD);
	assign rec_re = (state_q == ST_RRD);
	assign sig_we = (state_q == ST_ALLOC);
	assign rec_we = (state_q == ST_ALLOC) || (state_q == ST_UPD);

	msp_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_sig_ram (
		.clk   (clk),
		.we    (sig_we),
		.waddr (e_q),
		.wdata (h_q),
		.re    (sig_re),
		.raddr (e_q),
		.rdata (sig_rd)
	);

	msp_ram #(.WIDTH($bits(rec_t)), .DEPTH(TABLE_ENTRIES)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (e_q),
		.wdata ((state_q == ST_ALLOC) ? ar : nr),
		.re    (rec_re),
		.raddr (e_q),
		.rdata (rec_rd)
	);

	msp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = mode ? ST_OUT : ST_HASH;
			ST_HASH: begin
				if (step_q == hn - 4'd1) begin
					if (cnt_q != '0) state_d = ST_SRD;
					else state_d = ST_ENT;
				end
			end
			ST_SRD: state_d = ST_SCMP;
			ST_SCMP: begin
				if (hit) state_d = ST_RRD;
				else if (e_nx != cnt_q) state_d = ST_SRD;
				else if (cnt_q >= TE_C) state_d = ST_OUT;
				else state_d = ST_ENT;
			end
			ST_RRD: state_d = ST_RLD;
			ST_RLD: state_d = ST_IVL;
			ST_IVL: state_d = div_req.start ? ST_DIV1 : ST_UPD;
			ST_DIV1: if (div_rsp.done) state_d = div_req.start ? ST_DIV2 : ST_UPD;
			ST_DIV2: if (div_rsp.done) state_d = ST_UPD;
			ST_UPD: state_d = ST_OUT;
			ST_ENT: if (bin_q == 4'd15) state_d = div_req.start ? ST_EDIV : ST_ALLOC;
			ST_EDIV: if (div_rsp.done) state_d = ST_ALLOC;
			ST_ALLOC: state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sess_ok_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && mode) sess_ok_q <= '0;
			if (state_q == ST_UPD || state_q == ST_ALLOC) sess_ok_q[e_q] <= 1'b1;
			if (state_q == ST_ALLOC) cnt_q <= cnt_q + CW'(1);
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sop_q  <= sop;
					type_q <= msg_type;
					pay_q  <= payload_bytes;
					cap_q  <= cap_in;
					vb_q   <= vbus_low_byte;
					cu_q   <= current_low_byte;
					te_q   <= temperature_low_byte;
					flg_q  <= event_flags;
					prv_q  <= previous_type;
					now_q  <= now_ms;
					h_q    <= FNV_BASIS;
					step_q <= '0;
					res_q  <= res_t'{status: STS_SRST, default: '0};
				end
			end
			ST_HASH: begin
				h_q    <= h_nx;
				step_q <= step_q + 4'd1;
				e_q    <= '0;
				bin_q  <= '0;
				acc_q  <= '0;
				ent_q  <= '0;
			end
			ST_SCMP: begin
				if (!hit) begin
					e_q   <= IW'(e_nx);
					bin_q <= '0;
					acc_q <= '0;
					ent_q <= '0;
					res_q <= res_t'{status: STS_FULL, default: '0};
				end
			end
			ST_RLD: rec_q <= rec_rd;
			ST_IVL: begin
				if (take) begin
					rec_q.isum <= isum_nx;
					rec_q.icnt <= icnt_nx;
				end
			end
			ST_DIV1: if (div_rsp.done && div_rsp.quotient == 32'd0) rec_q.freq <= '0;
			ST_DIV2: if (div_rsp.done) rec_q.freq <= div_rsp.quotient[19:0];
			ST_UPD: begin
				res_q.status <= STS_HIT;
				res_q.idx    <= 8'(e_q);
				res_q.cat    <= nr.cat;
				res_q.conf   <= nr.conf;
				res_q.ent    <= rec_q.ent;
				res_q.freq   <= nr.freq;
				res_q.hits   <= nr.sess;
				res_q.stab   <= nr.stab;
				res_q.chg    <= nr.chg;
			end
			ST_ENT: begin
				acc_q <= acc_nx;
				bin_q <= bin_q + 4'd1;
			end
			ST_EDIV: if (div_rsp.done) ent_q <= entropy_score_of(div_rsp.quotient);
			ST_ALLOC: begin
				res_q <= res_t'{status: STS_NEW, idx: 8'(e_q), conf: 7'd20, ent: ent_q,
					hits: 32'd1, default: '0};
			end
			ST_OUT: if (out_free) out_q <= res_q;
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign entry_index      = out_q.idx[3:0];
	assign category         = out_q.cat;
	assign confidence       = out_q.conf;
	assign entropy_score    = out_q.ent;
	assign frequency_milli  = out_q.freq;
	assign hit_count        = out_q.hits;
	assign stable_average   = out_q.stab;
	assign changing_average = out_q.chg;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= TE_C) else $error("entry count beyond table size");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2 || state_q == ST_EDIV))
		else $error("divider finished outside a wait state");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && out_stall) |=> (state_q == ST_OUT))
		else $error("result left while output register was busy");
`endif

endmodule

// ===== hdl/msp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module msp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/msp_div.sv =====
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
module msp_div import msp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [31:0] rem_q, quo_q, dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [33:0] trial;

	assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== tb/message_signature_profiler_tb.sv =====
// Testbench of the message signature profiler: random and directed messages against a predictor.
`timescale 1ns / 100ps

module message_signature_profiler_tb import msp_pkg::*; ;

	typedef struct {
		bit        mode;
		bit [7:0]  sop;
		bit [7:0]  msg_type;
		bit [63:0] payload;
		bit [3:0]  length;
		bit [7:0]  vbus;
		bit [7:0]  current;
		bit [7:0]  temperature;
		bit [2:0]  flags;
		bit [7:0]  prior_type;
		bit [31:0] now;
	} message_t;

	typedef struct {
		bit [1:0]  status;
		bit [3:0]  entry_index;
		bit [2:0]  category;
		bit [6:0]  confidence;
		bit [7:0]  entropy;
		bit [19:0] frequency;
		bit [31:0] hits;
		bit [3:0]  stable;
		bit [3:0]  changing;
	} profile_t;

	int mismatches = 0;

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	class profile_board;
		int        n_entries;
		bit [31:0] sig[16];
		bit [63:0] last_pay[16];
		bit [31:0] sess[16];
		bit [31:0] total[16];
		bit [31:0] last_t[16];
		bit [31:0] iv_sum[16];
		bit [31:0] iv_cnt[16];
		bit [19:0] freq[16];
		bit [3:0]  stab[16];
		bit [3:0]  chg[16];
		bit [31:0] flips[16];
		bit [7:0]  vm[16];
		bit [7:0]  cm[16];
		bit [7:0]  tm[16];
		bit [15:0] rl[16];
		bit [15:0] al[16];
		bit [7:0]  lt[16];
		bit [2:0]  cat[16];
		bit [6:0]  conf[16];
		bit [7:0]  ent[16];
		profile_t  pending[$];

		function new();
			n_entries = 0;
		endfunction

		function automatic int lg(int n);
			int tbl[17] = '{0, 0, 4096, 6492, 8192, 9510, 10592, 11497, 12288,
				12992, 13622, 14200, 14723, 15210, 15655, 16077, 16473};
			return tbl[n];
		endfunction

		function automatic bit [7:0] nibble_score(bit [63:0] p, int len);
			int hist[16];
			int tot, acc, bits, d;
			bit [7:0] b;
			if (len == 0)
				return 0;
			foreach (hist[i]) hist[i] = 0;
			for (int k = 0; k < len; k++) begin
				b = p[k*8 +: 8];
				hist[b[3:0]]++;
				hist[b[7:4]]++;
			end
			tot = len * 2;
			acc = 0;
			for (int k = 0; k < 16; k++) begin
				if (hist[k] > 0) begin
					d = (lg(tot) > lg(hist[k])) ? lg(tot) - lg(hist[k]) : 0;
					acc += hist[k] * d;
				end
			end
			bits = (acc / tot + 2048) / 4096;
			if (bits > 4)
				bits = 4;
			return 8'((bits * 255) / 4);
		endfunction

		function automatic void note_message(message_t m);
			profile_t r;
			bit [31:0] h, iv, mean;
			int cap, e, nst, nch, cf;
			bit [7:0] a, b;
			bit any;
			r = '{default: 0};
			if (m.mode) begin
				foreach (sess[i]) sess[i] = 0;
				r.status = STS_SRST;
				pending.push_back(r);
				return;
			end
			cap = (m.length > 8) ? 8 : m.length;
			h = (FNV_BASIS ^ m.sop) * FNV_PRIME;
			h = (h ^ m.msg_type) * FNV_PRIME;
			for (int k = 0; k < 6 && k < cap; k++)
				h = (h ^ m.payload[k*8 +: 8]) * FNV_PRIME;
			for (e = 0; e < n_entries; e++)
				if (sig[e] == h) break;
			if (e < n_entries) begin
				if (last_t[e] != 0 && sess[e] > 0) begin
					iv = m.now - last_t[e];
					if (iv > 0) begin
						iv_sum[e] += iv;
						iv_cnt[e]++;
						if (iv_cnt[e] > 0) begin
							mean = iv_sum[e] / iv_cnt[e];
							freq[e] = (mean > 0) ? 20'(FREQ_SCALE / mean) : 20'd0;
						end
					end
				end
				sess[e]++;
				total[e]++;
				last_t[e] = m.now;
				nst = 0;
				nch = 0;
				for (int k = 0; k < cap; k++) begin
					a = last_pay[e][k*8 +: 8];
					b = m.payload[k*8 +: 8];
					if (a == b) nst++; else nch++;
					flips[e] += $countones(a ^ b);
					last_pay[e][k*8 +: 8] = b;
					if (b == m.vbus && vm[e] != 8'hFF) vm[e]++;
					if (b == m.current && cm[e] != 8'hFF) cm[e]++;
					if (b == m.temperature && tm[e] != 8'hFF) tm[e]++;
				end
				stab[e] = 4'((int'(stab[e]) + nst) >> 1);
				chg[e] = 4'((int'(chg[e]) + nch) >> 1);
				if (m.flags[0]) rl[e]++;
				if (m.flags[2]) al[e]++;
				if (m.prior_type != 8'hFF) lt[e] = m.prior_type;
				any = vm[e] > 0 || cm[e] > 0 || tm[e] > 0;
				if (rl[e] > 0 && sess[e] <= 32'(rl[e]) + 2)
					cat[e] = CAT_RESET;
				else if (iv_cnt[e] >= 2 && sess[e] >= 3 && freq[e] >= 1000 && any)
					cat[e] = CAT_TELEMETRY;
				else if (iv_cnt[e] >= 3 && freq[e] >= 1000)
					cat[e] = CAT_PERIODIC;
				else if (lt[e] != 8'hFF && sess[e] >= 3)
					cat[e] = CAT_RESPONSE;
				else if (al[e] > 0 && sess[e] <= 32'(al[e]) + 2)
					cat[e] = CAT_STATE;
				else
					cat[e] = CAT_NONE;
				cf = 40;
				if (total[e] >= 2) cf += 20;
				if (iv_cnt[e] >= 3) cf += 15;
				if (sess[e] >= 10) cf += 15;
				if (vm[e] > 0 || cm[e] > 0 || rl[e] > 0) cf += 10;
				conf[e] = 7'((cf > 100) ? 100 : cf);
				r.status = STS_HIT;
			end else begin
				if (n_entries >= 16) begin
					r.status = STS_FULL;
					pending.push_back(r);
					return;
				end
				e = n_entries;
				sig[e] = h;
				last_pay[e] = 0;
				for (int k = 0; k < cap; k++)
					last_pay[e][k*8 +: 8] = m.payload[k*8 +: 8];
				ent[e] = nibble_score(m.payload, cap);
				sess[e] = 1;
				total[e] = 1;
				last_t[e] = m.now;
				iv_sum[e] = 0;
				iv_cnt[e] = 0;
				freq[e] = 0;
				stab[e] = 0;
				chg[e] = 0;
				flips[e] = 0;
				vm[e] = 0;
				cm[e] = 0;
				tm[e] = 0;
				rl[e] = 0;
				al[e] = 0;
				lt[e] = (m.prior_type != 8'hFF) ? m.prior_type : 8'd0;
				cat[e] = CAT_NONE;
				conf[e] = 20;
				n_entries++;
				r.status = STS_NEW;
			end
			r.entry_index = 4'(e);
			r.category = cat[e];
			r.confidence = conf[e];
			r.entropy = ent[e];
			r.frequency = freq[e];
			r.hits = sess[e];
			r.stable = stab[e];
			r.changing = chg[e];
			pending.push_back(r);
		endfunction

		task automatic check_result(profile_t got);
			profile_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result, status", got.status, 0);
				return;
			end
			w = pending.pop_front();
			if (got.status != w.status) report_mismatch("status", got.status, w.status);
			if (got.entry_index != w.entry_index)
				report_mismatch("entry_index", got.entry_index, w.entry_index);
			if (got.category != w.category) report_mismatch("category", got.category, w.category);
			if (got.confidence != w.confidence)
				report_mismatch("confidence", got.confidence, w.confidence);
			if (got.entropy != w.entropy) report_mismatch("entropy_score", got.entropy, w.entropy);
			if (got.frequency != w.frequency)
				report_mismatch("frequency_milli", got.frequency, w.frequency);
			if (got.hits != w.hits) report_mismatch("hit_count", got.hits, w.hits);
			if (got.stable != w.stable) report_mismatch("stable_average", got.stable, w.stable);
			if (got.changing != w.changing)
				report_mismatch("changing_average", got.changing, w.changing);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        mode = 0;
	logic [7:0]  sop = 0;
	logic [7:0]  msg_type = 0;
	logic [63:0] payload_bytes = 0;
	logic [3:0]  payload_length = 0;
	logic [7:0]  vbus_low_byte = 0;
	logic [7:0]  current_low_byte = 0;
	logic [7:0]  temperature_low_byte = 0;
	logic [2:0]  event_flags = 0;
	logic [7:0]  previous_type = 0;
	logic [31:0] now_ms = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic [3:0]  entry_index;
	logic [2:0]  category;
	logic [6:0]  confidence;
	logic [7:0]  entropy_score;
	logic [19:0] frequency_milli;
	logic [31:0] hit_count;
	logic [3:0]  stable_average;
	logic [3:0]  changing_average;

	message_signature_profiler uut (.*);

	profile_board board = new();
	int results_seen = 0;
	int cycles = 0;
	bit [31:0] clock_ms = 32'd5;
	message_t pool[12];

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_message(message_t m);
		int gap;
		gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		mode <= m.mode;
		sop <= m.sop;
		msg_type <= m.msg_type;
		payload_bytes <= m.payload;
		payload_length <= m.length;
		vbus_low_byte <= m.vbus;
		current_low_byte <= m.current;
		temperature_low_byte <= m.temperature;
		event_flags <= m.flags;
		previous_type <= m.prior_type;
		now_ms <= m.now;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_message(m);
	endtask

	function automatic message_t random_message();
		message_t m;
		m.mode = 0;
		m.sop = 8'($urandom);
		m.msg_type = 8'($urandom);
		m.payload = {$urandom, $urandom};
		m.length = 4'($urandom);
		m.vbus = 8'($urandom);
		m.current = 8'($urandom);
		m.temperature = 8'($urandom);
		m.flags = 3'($urandom);
		m.prior_type = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
		m.now = $urandom;
		return m;
	endfunction

	function automatic message_t pool_message();
		message_t m;
		int c;
		m = pool[$urandom_range(0, 11)];
		c = (m.length > 8) ? 8 : m.length;
		for (int k = 6; k < 8; k++)
			if ($urandom_range(0, 1)) m.payload[k*8 +: 8] = 8'($urandom);
		if (c > 0 && $urandom_range(0, 2) == 0)
			m.vbus = m.payload[$urandom_range(0, c - 1)*8 +: 8];
		else
			m.vbus = 8'($urandom);
		if (c > 0 && $urandom_range(0, 3) == 0)
			m.current = m.payload[$urandom_range(0, c - 1)*8 +: 8];
		else
			m.current = 8'($urandom);
		if (c > 0 && $urandom_range(0, 3) == 0)
			m.temperature = m.payload[$urandom_range(0, c - 1)*8 +: 8];
		else
			m.temperature = 8'($urandom);
		m.flags = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0;
		m.prior_type = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom);
		case ($urandom_range(0, 19))
			0: m.now = 0;
			1: m.now = clock_ms;
			2: m.now = $urandom;
			default: begin
				clock_ms += $urandom_range(1, 1500);
				m.now = clock_ms;
			end
		endcase
		return m;
	endfunction

	initial begin
		message_t m;
		message_t base;
		foreach (pool[i]) begin
			pool[i] = random_message();
			pool[i].length = (i < 2) ? 4'(i) : 4'($urandom_range(2, 15));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, repeats, equal ticks, flags and session reset
		base = '{default: 0};
		base.now = 0;
		send_message(base);
		base.now = 100;
		send_message(base);
		base.now = 100;
		send_message(base);
		m = '{mode: 0, sop: 8'hFF, msg_type: 8'hFF, payload: '1, length: 4'hF,
			vbus: 8'hFF, current: 8'hFF, temperature: 8'hFF, flags: 3'b111,
			prior_type: 8'hFF, now: 32'hFFFF_FFF0};
		send_message(m);
		m.now = 32'h0000_0010;
		send_message(m);
		m.payload = 64'h0123_4567_89AB_CDEF;
		m.length = 8;
		m.flags = 3'b001;
		m.prior_type = 8'h00;
		for (int i = 0; i < 4; i++) begin
			m.now = 32'h100 + i * 200;
			send_message(m);
		end
		m.mode = 1;
		send_message(m);
		m.mode = 0;
		m.now = 32'h1000;
		send_message(m);
		m.flags = 3'b100;
		m.payload[63:48] = 16'h5555;
		m.now = 32'h1001;
		send_message(m);
		for (int i = 0; i < 12; i++)
			send_message(random_message());

		for (int i = 0; i < 1230; i++) begin
			if ($urandom_range(0, 39) == 0) begin
				m = random_message();
				m.mode = 1;
			end else if ($urandom_range(0, 9) == 0)
				m = random_message();
			else
				m = pool_message();
			send_message(m);
		end
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		int w;
		profile_t got;
		@(posedge arst_n);
		forever begin
			if (results_seen == 200)
				w = 600;
			else
				w = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 11);
			if (w > 0) begin
				out_stall <= 1;
				repeat (w) @(posedge clk);
				out_stall <= 0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
			got.status = status;
			got.entry_index = entry_index;
			got.category = category;
			got.confidence = confidence;
			got.entropy = entropy_score;
			got.frequency = frequency_milli;
			got.hits = hit_count;
			got.stable = stable_average;
			got.changing = changing_average;
			board.check_result(got);
			results_seen++;
		end
	end

endmodule

// ===== files.f =====
hdl/msp_pkg.sv
hdl/msp_ram.sv
hdl/msp_div.sv
hdl/message_signature_profiler.sv
tb/message_signature_profiler_tb.sv
